// File: src/assert_macros.svh
// assertion helpers shared by the rtl, clocked on clock and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// property checked in the same cycle as its trigger
`define ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// property checked in the cycle after its trigger
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/lca_pkg.sv
package lca_pkg;

   localparam int NodeW      = 4;
   localparam int MasterW    = 5;
   localparam int RoundW     = 64;
   localparam int PropW      = 64;
   localparam int SecsW      = 16;
   localparam int NowW       = 32;
   localparam int ExpW       = 33;
   localparam int KindW      = 3;

   localparam int QueueDepth = 2;
   localparam int CountW     = $clog2(QueueDepth + 1);
   localparam int PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

   localparam logic [KindW-1:0] KIND_PREP_REJECT = 3'd0;
   localparam logic [KindW-1:0] KIND_OPEN        = 3'd1;
   localparam logic [KindW-1:0] KIND_PREV        = 3'd2;
   localparam logic [KindW-1:0] KIND_PROP_REJECT = 3'd3;
   localparam logic [KindW-1:0] KIND_ACCEPT      = 3'd4;

   typedef struct packed {
      logic              is_propose;
      logic [NodeW-1:0]  sender;
      logic [RoundW-1:0] round;
      logic [PropW-1:0]  proposal;
      logic [NodeW-1:0]  owner;
      logic [SecsW-1:0]  secs;
      logic [NowW-1:0]   now;
   } cmd_type;

   typedef struct packed {
      logic [NodeW-1:0]  dest_node;
      logic [KindW-1:0]  reply_kind;
      logic [NodeW-1:0]  from_node;
      logic [PropW-1:0]  echo_proposal;
      logic [PropW-1:0]  prior_proposal;
      logic [NodeW-1:0]  prior_owner;
      logic [SecsW-1:0]  prior_secs;
      logic [RoundW-1:0] reply_round;
   } rsp_type;

   function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] ptr);
      logic [PtrW-1:0] nxt;
      if (ptr == PtrW'(QueueDepth - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PtrW'(1);
      end
      return nxt;
   endfunction

endpackage

// File: src/lca_front.sv
`include "assert_macros.svh"

module lca_front
   import lca_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_type,
   input  logic [NodeW-1:0]          req_sender_node,
   input  logic [RoundW-1:0]         req_round_id,
   input  logic [PropW-1:0]          req_proposal_num,
   input  logic [NodeW-1:0]          req_owner_node,
   input  logic [SecsW-1:0]          req_lease_secs,
   input  logic [NowW-1:0]           req_now_secs,
   input  logic [RoundW-1:0]         req_local_round,
   input  logic signed [MasterW-1:0] req_current_master,
   output logic                      cmd_valid,
   output cmd_type                   cmd_data,
   input  logic                      cmd_pop
);

   logic [CountW-1:0] count_ff, count_in;
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   cmd_type           entry_ff [QueueDepth];

   logic    master_match;
   logic    stale;
   logic    accept;
   logic    do_write;
   logic    do_read;
   cmd_type new_cmd;

   // a negative master never matches any sender
   assign master_match = !req_current_master[MasterW-1] &&
                         (req_current_master[NodeW-1:0] == req_sender_node);
   assign stale        = !req_type && (req_round_id < req_local_round) && !master_match;

   assign req_full  = (count_ff == CountW'(QueueDepth));
   assign accept    = req_push && !req_full;
   assign do_write  = accept && !stale;
   assign cmd_valid = (count_ff != '0);
   assign do_read   = cmd_pop && cmd_valid;
   assign cmd_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.is_propose = req_type;
      new_cmd.sender     = req_sender_node;
      new_cmd.round      = req_round_id;
      new_cmd.proposal   = req_proposal_num;
      new_cmd.owner      = req_owner_node;
      new_cmd.secs       = req_lease_secs;
      new_cmd.now        = req_now_secs;
   end

   always_comb begin
      wr_ptr_in = do_write ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_read ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      case ({do_write, do_read})
         2'b10:   count_in = count_ff + CountW'(1);
         2'b01:   count_in = count_ff - CountW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   `ASSERT_ALWAYS(a_front_count_bound, count_ff <= CountW'(QueueDepth), "front queue overflow")
   `ASSERT_NEXT(a_front_stale_dropped, accept && stale && !do_read, $stable(count_ff),
                "stale prepare entered the queue")
   `ASSERT_SAME(a_front_ptr_sync, count_ff == '0, wr_ptr_ff == rd_ptr_ff,
                "empty queue with pointers apart")

endmodule

// File: src/lca_back.sv
`include "assert_macros.svh"

module lca_back
   import lca_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  cmd_type          cmd_data,
   output logic             cmd_pop,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [NodeW-1:0] csr_own_node,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsp_type          rsp_data
);

   logic [NodeW-1:0]  own_node_ff;
   logic [PropW-1:0]  promised_ff, promised_in;
   logic              has_accepted_ff, has_accepted_in;
   logic [PropW-1:0]  acc_proposal_ff, acc_proposal_in;
   logic [NodeW-1:0]  acc_owner_ff, acc_owner_in;
   logic [SecsW-1:0]  acc_secs_ff, acc_secs_in;
   logic [ExpW-1:0]   expiry_ff, expiry_in;

   logic [CountW-1:0] count_ff, count_in;
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   rsp_type           entry_ff [QueueDepth];

   logic    out_full;
   logic    do_read;
   logic    lease_live;
   logic    below_promise;
   logic    accept_propose;
   rsp_type new_rsp;

   assign csr_ready = 1'b1;

   assign out_full  = (count_ff == CountW'(QueueDepth));
   assign rsp_empty = (count_ff == '0);
   assign do_read   = rsp_pop && !rsp_empty;
   assign cmd_pop   = cmd_valid && (!out_full || do_read);
   assign rsp_data  = entry_ff[rd_ptr_ff];

   // lease dropped once its expiry is strictly older than now
   assign lease_live     = has_accepted_ff && !(expiry_ff < ExpW'(cmd_data.now));
   assign below_promise  = cmd_data.proposal < promised_ff;
   assign accept_propose = cmd_data.is_propose && !below_promise;

   always_comb begin
      promised_in     = promised_ff;
      has_accepted_in = lease_live;
      acc_proposal_in = acc_proposal_ff;
      acc_owner_in    = acc_owner_ff;
      acc_secs_in     = acc_secs_ff;
      expiry_in       = expiry_ff;

      new_rsp.dest_node      = cmd_data.sender;
      new_rsp.reply_kind     = KIND_PREP_REJECT;
      new_rsp.from_node      = own_node_ff;
      new_rsp.echo_proposal  = cmd_data.proposal;
      new_rsp.prior_proposal = '0;
      new_rsp.prior_owner    = '0;
      new_rsp.prior_secs     = '0;
      new_rsp.reply_round    = cmd_data.round;

      if (!cmd_data.is_propose) begin
         if (below_promise) begin
            new_rsp.reply_kind = KIND_PREP_REJECT;
         end else begin
            promised_in = cmd_data.proposal;
            if (!lease_live) begin
               new_rsp.reply_kind = KIND_OPEN;
            end else begin
               new_rsp.reply_kind     = KIND_PREV;
               new_rsp.prior_proposal = acc_proposal_ff;
               new_rsp.prior_owner    = acc_owner_ff;
               new_rsp.prior_secs     = acc_secs_ff;
            end
         end
      end else begin
         if (below_promise) begin
            new_rsp.reply_kind = KIND_PROP_REJECT;
         end else begin
            has_accepted_in    = 1'b1;
            acc_proposal_in    = cmd_data.proposal;
            acc_owner_in       = cmd_data.owner;
            acc_secs_in        = cmd_data.secs;
            expiry_in          = ExpW'(cmd_data.now) + ExpW'(cmd_data.secs);
            new_rsp.reply_kind = KIND_ACCEPT;
         end
      end
   end

   always_comb begin
      wr_ptr_in = cmd_pop ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_read ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      case ({cmd_pop, do_read})
         2'b10:   count_in = count_ff + CountW'(1);
         2'b01:   count_in = count_ff - CountW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_node_ff     <= '0;
         promised_ff     <= '0;
         has_accepted_ff <= 1'b0;
         acc_proposal_ff <= '0;
         acc_owner_ff    <= '0;
         acc_secs_ff     <= '0;
         expiry_ff       <= '0;
         count_ff        <= '0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            own_node_ff <= csr_own_node;
         end
         if (cmd_pop) begin
            promised_ff     <= promised_in;
            has_accepted_ff <= has_accepted_in;
            acc_proposal_ff <= acc_proposal_in;
            acc_owner_ff    <= acc_owner_in;
            acc_secs_ff     <= acc_secs_in;
            expiry_ff       <= expiry_in;
         end
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         entry_ff[wr_ptr_ff] <= new_rsp;
      end
   end

   `ASSERT_ALWAYS(a_back_count_bound, count_ff <= CountW'(QueueDepth), "reply queue overflow")
   `ASSERT_NEXT(a_back_accept_holds, cmd_pop && accept_propose, has_accepted_ff,
                "accepted propose left no lease")
   `ASSERT_NEXT(a_back_promise_update, cmd_pop && !cmd_data.is_propose && !below_promise,
                promised_ff == $past(cmd_data.proposal), "promise not raised by prepare")

endmodule

// File: src/lease_consensus_acceptor.sv
// Lease acceptor: takes one prepare or propose request per clock while req_full is low and
// returns at most one reply per request, in request order; a prepare whose round is behind
// the local round and whose sender is not the known master gets no reply and leaves the
// state alone. A front stage checks staleness on the way in and a back stage judges the
// request against the promised proposal and the accepted lease; two-entry queues sit
// between the front and the back and in front of the reply ports, so a request is taken
// every cycle while replies keep being popped, and req_full rises only when both queues are
// backed up. own_node is written over the csr port, which is always ready; the user must
// write it only while no request is in flight, and the block itself does not enforce this.
module lease_consensus_acceptor
   import lca_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_type,
   input  logic [NodeW-1:0]          req_sender_node,
   input  logic [RoundW-1:0]         req_round_id,
   input  logic [PropW-1:0]          req_proposal_num,
   input  logic [NodeW-1:0]          req_owner_node,
   input  logic [SecsW-1:0]          req_lease_secs,
   input  logic [NowW-1:0]           req_now_secs,
   input  logic [RoundW-1:0]         req_local_round,
   input  logic signed [MasterW-1:0] req_current_master,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [NodeW-1:0]          rsp_dest_node,
   output logic [KindW-1:0]          rsp_reply_kind,
   output logic [NodeW-1:0]          rsp_from_node,
   output logic [PropW-1:0]          rsp_echo_proposal,
   output logic [PropW-1:0]          rsp_prior_proposal,
   output logic [NodeW-1:0]          rsp_prior_owner,
   output logic [SecsW-1:0]          rsp_prior_secs,
   output logic [RoundW-1:0]         rsp_reply_round,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [NodeW-1:0]          csr_own_node
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_data;
   rsp_type rsp_data;

   lca_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_type           (req_type),
      .req_sender_node    (req_sender_node),
      .req_round_id       (req_round_id),
      .req_proposal_num   (req_proposal_num),
      .req_owner_node     (req_owner_node),
      .req_lease_secs     (req_lease_secs),
      .req_now_secs       (req_now_secs),
      .req_local_round    (req_local_round),
      .req_current_master (req_current_master),
      .cmd_valid          (cmd_valid),
      .cmd_data           (cmd_data),
      .cmd_pop            (cmd_pop)
   );

   lca_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd_data     (cmd_data),
      .cmd_pop      (cmd_pop),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_own_node (csr_own_node),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data)
   );

   assign rsp_dest_node      = rsp_data.dest_node;
   assign rsp_reply_kind     = rsp_data.reply_kind;
   assign rsp_from_node      = rsp_data.from_node;
   assign rsp_echo_proposal  = rsp_data.echo_proposal;
   assign rsp_prior_proposal = rsp_data.prior_proposal;
   assign rsp_prior_owner    = rsp_data.prior_owner;
   assign rsp_prior_secs     = rsp_data.prior_secs;
   assign rsp_reply_round    = rsp_data.reply_round;

endmodule

// File: tb/tb_lease_consensus_acceptor.sv
module tb_lease_consensus_acceptor
   import lca_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic                      is_propose;
      logic [NodeW-1:0]          sender;
      logic [RoundW-1:0]         round;
      logic [PropW-1:0]          proposal;
      logic [NodeW-1:0]          owner;
      logic [SecsW-1:0]          secs;
      logic [NowW-1:0]           now;
      logic [RoundW-1:0]         local_round;
      logic signed [MasterW-1:0] master;
   } lease_req_type;

   class lease_board_type;
      logic [NodeW-1:0] own_node;
      logic [PropW-1:0] promised;
      logic             has_lease;
      logic [PropW-1:0] lease_prop;
      logic [NodeW-1:0] lease_owner;
      logic [SecsW-1:0] lease_secs;
      logic [ExpW-1:0]  lease_expiry;
      rsp_type          replies_due[$];
      int               errors;
      int               stale_drops;
      int               kind_seen[5];

      function new();
         own_node     = '0;
         promised     = '0;
         has_lease    = 1'b0;
         lease_prop   = '0;
         lease_owner  = '0;
         lease_secs   = '0;
         lease_expiry = '0;
         errors       = 0;
         stale_drops  = 0;
         foreach (kind_seen[k]) kind_seen[k] = 0;
      endfunction

      function void note_request(lease_req_type r);
         rsp_type rep;
         int      sender_i;
         int      master_i;
         sender_i = int'(r.sender);
         master_i = int'(r.master);
         if (!r.is_propose && r.round < r.local_round && sender_i != master_i) begin
            stale_drops++;
            return;
         end
         if (has_lease && lease_expiry < ExpW'(r.now)) begin
            has_lease = 1'b0;
         end
         rep = '0;
         rep.dest_node     = r.sender;
         rep.from_node     = own_node;
         rep.echo_proposal = r.proposal;
         rep.reply_round   = r.round;
         if (!r.is_propose) begin
            if (r.proposal < promised) begin
               rep.reply_kind = KIND_PREP_REJECT;
            end else begin
               promised = r.proposal;
               if (!has_lease) begin
                  rep.reply_kind = KIND_OPEN;
               end else begin
                  rep.reply_kind     = KIND_PREV;
                  rep.prior_proposal = lease_prop;
                  rep.prior_owner    = lease_owner;
                  rep.prior_secs     = lease_secs;
               end
            end
         end else begin
            if (r.proposal < promised) begin
               rep.reply_kind = KIND_PROP_REJECT;
            end else begin
               has_lease      = 1'b1;
               lease_prop     = r.proposal;
               lease_owner    = r.owner;
               lease_secs     = r.secs;
               lease_expiry   = ExpW'(r.now) + ExpW'(r.secs);
               rep.reply_kind = KIND_ACCEPT;
            end
         end
         replies_due.push_back(rep);
      endfunction

      function void cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_reply(rsp_type got);
         rsp_type want;
         if (replies_due.size() == 0) begin
            $error("reply with no request waiting: kind %0d dest %0d",
                   got.reply_kind, got.dest_node);
            errors++;
            return;
         end
         want = replies_due.pop_front();
         cmp_field("dest_node", want.dest_node, got.dest_node);
         cmp_field("reply_kind", want.reply_kind, got.reply_kind);
         cmp_field("from_node", want.from_node, got.from_node);
         cmp_field("echo_proposal", want.echo_proposal, got.echo_proposal);
         cmp_field("prior_proposal", want.prior_proposal, got.prior_proposal);
         cmp_field("prior_owner", want.prior_owner, got.prior_owner);
         cmp_field("prior_secs", want.prior_secs, got.prior_secs);
         cmp_field("reply_round", want.reply_round, got.reply_round);
         if (got.reply_kind <= KIND_ACCEPT) kind_seen[got.reply_kind]++;
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic                      req_type = 1'b0;
   logic [NodeW-1:0]          req_sender_node = '0;
   logic [RoundW-1:0]         req_round_id = '0;
   logic [PropW-1:0]          req_proposal_num = '0;
   logic [NodeW-1:0]          req_owner_node = '0;
   logic [SecsW-1:0]          req_lease_secs = '0;
   logic [NowW-1:0]           req_now_secs = '0;
   logic [RoundW-1:0]         req_local_round = '0;
   logic signed [MasterW-1:0] req_current_master = '0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic [NodeW-1:0]          rsp_dest_node;
   logic [KindW-1:0]          rsp_reply_kind;
   logic [NodeW-1:0]          rsp_from_node;
   logic [PropW-1:0]          rsp_echo_proposal;
   logic [PropW-1:0]          rsp_prior_proposal;
   logic [NodeW-1:0]          rsp_prior_owner;
   logic [SecsW-1:0]          rsp_prior_secs;
   logic [RoundW-1:0]         rsp_reply_round;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [NodeW-1:0]          csr_own_node = '0;

   lease_board_type  board;
   bit               hold_pop = 1'b0;
   int               own_writes = 0;
   int               items_sent = 0;
   logic [NowW-1:0]  tnow = '0;
   logic [RoundW-1:0] cur_local = '0;
   logic [PropW-1:0] last_prop = '0;

   lease_consensus_acceptor u_top (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_type           (req_type),
      .req_sender_node    (req_sender_node),
      .req_round_id       (req_round_id),
      .req_proposal_num   (req_proposal_num),
      .req_owner_node     (req_owner_node),
      .req_lease_secs     (req_lease_secs),
      .req_now_secs       (req_now_secs),
      .req_local_round    (req_local_round),
      .req_current_master (req_current_master),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_dest_node      (rsp_dest_node),
      .rsp_reply_kind     (rsp_reply_kind),
      .rsp_from_node      (rsp_from_node),
      .rsp_echo_proposal  (rsp_echo_proposal),
      .rsp_prior_proposal (rsp_prior_proposal),
      .rsp_prior_owner    (rsp_prior_owner),
      .rsp_prior_secs     (rsp_prior_secs),
      .rsp_reply_round    (rsp_reply_round),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_own_node       (csr_own_node)
   );

   always #6 clock = ~clock;

   // handshake monitor
   always @(posedge clock) begin
      lease_req_type seen;
      rsp_type       got;
      if (!reset) begin
         if (csr_valid && csr_ready) board.own_node = csr_own_node;
         if (req_push && !req_full) begin
            seen.is_propose  = req_type;
            seen.sender      = req_sender_node;
            seen.round       = req_round_id;
            seen.proposal    = req_proposal_num;
            seen.owner       = req_owner_node;
            seen.secs        = req_lease_secs;
            seen.now         = req_now_secs;
            seen.local_round = req_local_round;
            seen.master      = req_current_master;
            board.note_request(seen);
         end
         if (rsp_pop && !rsp_empty) begin
            got.dest_node      = rsp_dest_node;
            got.reply_kind     = rsp_reply_kind;
            got.from_node      = rsp_from_node;
            got.echo_proposal  = rsp_echo_proposal;
            got.prior_proposal = rsp_prior_proposal;
            got.prior_owner    = rsp_prior_owner;
            got.prior_secs     = rsp_prior_secs;
            got.reply_round    = rsp_reply_round;
            board.check_reply(got);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic lease_req_type mk(bit is_prop, int sender, logic [RoundW-1:0] round,
                                        logic [PropW-1:0] prop, int owner, int secs,
                                        logic [NowW-1:0] now, logic [RoundW-1:0] local_round,
                                        int master);
      lease_req_type it;
      it.is_propose  = is_prop;
      it.sender      = NodeW'(sender);
      it.round       = round;
      it.proposal    = prop;
      it.owner       = NodeW'(owner);
      it.secs        = SecsW'(secs);
      it.now         = now;
      it.local_round = local_round;
      it.master      = MasterW'(master);
      return it;
   endfunction

   function automatic lease_req_type make_request();
      lease_req_type    it;
      int               r;
      logic [PropW-1:0] base;
      base = board.promised;
      it.sender = NodeW'($urandom_range(0, 15));
      it.owner  = NodeW'($urandom_range(0, 15));
      if ($urandom_range(0, 99) < 4) tnow = $urandom();
      else tnow = tnow + $urandom_range(0, 3);
      it.now = tnow;
      it.secs = ($urandom_range(0, 99) < 85) ? SecsW'($urandom_range(0, 8))
                                             : SecsW'($urandom_range(0, 65535));
      it.is_propose = ($urandom_range(0, 99) < 45);
      r = $urandom_range(0, 99);
      if (it.is_propose && r < 65) begin
         it.proposal = last_prop;
      end else if (r < 4) begin
         it.proposal = {$urandom(), $urandom()};
      end else if (r < 22) begin
         it.proposal = (base > 3) ? base - $urandom_range(1, 3) : '0;
      end else begin
         it.proposal = (base > {PropW{1'b1}} - 3) ? base : base + $urandom_range(0, 2);
      end
      if (!it.is_propose) last_prop = it.proposal;
      r = $urandom_range(0, 99);
      if (r < 15) cur_local = {$urandom(), $urandom()};
      else if (r < 30) cur_local = cur_local + 1;
      it.local_round = cur_local;
      r = $urandom_range(0, 99);
      if (r < 70) it.round = cur_local + $urandom_range(0, 1);
      else if (r < 90) it.round = cur_local - $urandom_range(1, 2);
      else it.round = {$urandom(), $urandom()};
      r = $urandom_range(0, 99);
      if (r < 35) it.master = MasterW'(it.sender);
      else if (r < 55) it.master = MasterW'(-1);
      else it.master = MasterW'($urandom_range(0, 15));
      return it;
   endfunction

   task automatic offer(lease_req_type it, int gap);
      req_push           <= 1'b1;
      req_type           <= it.is_propose;
      req_sender_node    <= it.sender;
      req_round_id       <= it.round;
      req_proposal_num   <= it.proposal;
      req_owner_node     <= it.owner;
      req_lease_secs     <= it.secs;
      req_now_secs       <= it.now;
      req_local_round    <= it.local_round;
      req_current_master <= it.master;
      do @(posedge clock); while (req_full);
      items_sent++;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_own(logic [NodeW-1:0] value);
      csr_valid    <= 1'b1;
      csr_own_node <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      own_writes++;
   endtask

   // drain replies, then allow a dropped item to clear the pipe
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (board.replies_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic run_phase(int count, logic [NodeW-1:0] own, bit with_hold);
      write_own(own);
      for (int i = 0; i < count; i++) begin
         if (with_hold && i == count / 2) hold_pop = 1'b1;
         offer(make_request(), hold_pop ? 0 : pick_gap());
      end
      settle();
   endtask

   // receiver
   initial begin
      int run_len;
      int gap;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_pop) begin
            rsp_pop <= 1'b0;
            repeat (250) @(posedge clock);
            hold_pop = 1'b0;
         end else begin
            run_len = $urandom_range(1, 30);
            rsp_pop <= 1'b1;
            repeat (run_len) @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_pop <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   initial begin
      lease_req_type directed[$];
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed.push_back(mk(0, 1, 0, 5, 0, 0, 100, 0, 0));
      directed.push_back(mk(0, 2, 0, 3, 0, 0, 100, 0, 0));
      directed.push_back(mk(0, 3, 0, 5, 0, 0, 100, 0, 0));
      directed.push_back(mk(1, 4, 0, 4, 7, 10, 100, 0, 0));
      directed.push_back(mk(1, 5, 0, 5, 7, 10, 100, 0, 0));
      directed.push_back(mk(0, 6, 0, 6, 0, 0, 110, 0, 0));
      directed.push_back(mk(0, 7, 0, 7, 0, 0, 111, 0, 0));
      // stale prepares, sender not master and no master at all
      directed.push_back(mk(0, 2, 3, 7, 0, 0, 111, 4, 5));
      directed.push_back(mk(0, 9, 0, 7, 0, 0, 111, '1, -1));
      // behind but from the master
      directed.push_back(mk(0, 5, 3, 7, 0, 0, 111, 4, 5));
      // behind round does not stop a propose; expiry past 32 bits
      directed.push_back(mk(1, 3, 1, 7, 15, 16'hFFFF, 32'hFFFF_FFFF, 9, -1));
      directed.push_back(mk(0, 3, 0, 8, 0, 0, 32'hFFFF_FFFF, 0, 3));
      directed.push_back(mk(1, 8, 0, 8, 0, 0, 0, 0, 0));
      directed.push_back(mk(0, 8, 0, 8, 0, 0, 0, 0, 0));
      directed.push_back(mk(0, 8, 0, 9, 0, 0, 1, 0, 0));
      directed.push_back(mk(1, 15, '1, '1, 15, 16'hFFFF, 32'hFFFF_FFFF, '1, 15));
      directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk(0, 4, 0, 9, 0, 0, 5, 0, 0));
      foreach (directed[i]) offer(directed[i], pick_gap());
      settle();

      tnow      = 10;
      last_prop = board.promised;
      run_phase(250, 4'd15, 1'b0);
      run_phase(250, 4'd0, 1'b1);
      run_phase(300, NodeW'($urandom_range(1, 14)), 1'b0);
      run_phase(300, 4'd9, 1'b1);

      $display("ran %0d requests over %0d own_node settings, %0d stale prepares dropped",
               items_sent, own_writes + 1, board.stale_drops);
      $display("replies: %0d prep rej, %0d open, %0d prev, %0d prop rej, %0d accepted",
               board.kind_seen[KIND_PREP_REJECT], board.kind_seen[KIND_OPEN],
               board.kind_seen[KIND_PREV], board.kind_seen[KIND_PROP_REJECT],
               board.kind_seen[KIND_ACCEPT]);
      if (board.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #8ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
